// ===== rtl/dmrl_pkg.sv =====
// ----------------------------------------------------------------------------
// dmrl_pkg: shared types, constants and functions for the motor ramp limiter
// Register indexes, reset values and the per-channel clamp, ramp and drive
// helpers used by the ramp limiter unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dmrl_pkg;

  localparam int unsigned SpeedW  = 8;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned TargetW = 16;
  localparam int unsigned StateW  = 9;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 16;

  typedef logic signed [StateW-1:0] speed_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMaxSpeed   = 2'd0,
    CfgMinSpeed   = 2'd1,
    CfgStepSize   = 2'd2,
    CfgTickPeriod = 2'd3
  } cfg_idx_e;

  localparam logic [SpeedW-1:0]  MaxSpeedRst   = 8'd255;
  localparam logic [SpeedW-1:0]  MinSpeedRst   = 8'd0;
  localparam logic [SpeedW-1:0]  StepSizeRst   = 8'd1;
  localparam logic [PeriodW-1:0] TickPeriodRst = 16'd10;

  // clamp a requested speed to plus or minus the limit
  function automatic speed_t clamp_target(input logic signed [TargetW-1:0] t,
                                          input logic [SpeedW-1:0] lim);
    logic signed [TargetW:0] t_s;
    logic signed [TargetW:0] lim_s;
    speed_t                  res;
    t_s   = {t[TargetW-1], t};
    lim_s = $signed({{(TargetW+1-SpeedW){1'b0}}, lim});
    if (t_s > lim_s) begin
      res = speed_t'(lim_s);
    end else if (t_s < -lim_s) begin
      res = speed_t'(-lim_s);
    end else begin
      res = speed_t'(t_s);
    end
    return res;
  endfunction

  // move toward the target by one step without overshoot
  function automatic speed_t ramp(input speed_t act, input speed_t tgt,
                                  input logic [SpeedW-1:0] step);
    logic signed [StateW+1:0] a_s;
    logic signed [StateW+1:0] t_s;
    logic signed [StateW+1:0] s_s;
    logic signed [StateW+1:0] n_s;
    a_s = {{2{act[StateW-1]}}, act};
    t_s = {{2{tgt[StateW-1]}}, tgt};
    s_s = $signed({{(StateW+2-SpeedW){1'b0}}, step});
    n_s = a_s;
    if (a_s < t_s) begin
      n_s = a_s + s_s;
      if (n_s > t_s) n_s = t_s;
    end else if (a_s > t_s) begin
      n_s = a_s - s_s;
      if (n_s < t_s) n_s = t_s;
    end
    return speed_t'(n_s);
  endfunction

  // drive magnitude: max clamp first, then the minimum floor
  function automatic logic [SpeedW-1:0] drive_mag(input speed_t act,
                                                  input logic [SpeedW-1:0] max_s,
                                                  input logic [SpeedW-1:0] min_s);
    logic [StateW-1:0] mag;
    logic [SpeedW-1:0] res;
    mag = act[StateW-1] ? StateW'(-act) : StateW'(act);
    if (mag > {1'b0, max_s}) begin
      res = max_s;
    end else begin
      res = mag[SpeedW-1:0];
    end
    if (res != '0 && res < min_s) res = min_s;
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dual_motor_ramp_limiter_unit.sv =====
// ----------------------------------------------------------------------------
// dual_motor_ramp_limiter_unit: two-channel motor speed ramp and drive limiter
// Stores clamped targets, ramps the actual speeds toward them on the tick
// schedule and reports direction and limited magnitude for each item.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+-----------------------------------------
//  in      | in_valid_i / in_stall_o | kind_i, target_left_i, target_right_i
//  out     | out_valid_o/out_stall_i | dir_*_o, duty_*_o, ramp_done_o
//  cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  one item per cycle while in_stall_o is low; its result goes straight into the output register
//  the state update and drive logic run in a single pass into that register
//  in_stall_o is high only while a result waits and out_stall_i holds it
//  reset loads the register defaults and clears targets, actuals, tick count
//  cfg_ready_o is always high
// ----------------------------------------------------------------------------
`default_nettype none

module dual_motor_ramp_limiter_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                kind_i,
  input  wire logic signed [dmrl_pkg::TargetW-1:0] target_left_i,
  input  wire logic signed [dmrl_pkg::TargetW-1:0] target_right_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic                                     dir_left_o,
  output logic [dmrl_pkg::SpeedW-1:0]              duty_left_o,
  output logic                                     dir_right_o,
  output logic [dmrl_pkg::SpeedW-1:0]              duty_right_o,
  output logic                                     ramp_done_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [dmrl_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [dmrl_pkg::CfgDatW-1:0]        cfg_data_i
);

  logic [dmrl_pkg::SpeedW-1:0]  max_speed_q;
  logic [dmrl_pkg::SpeedW-1:0]  min_speed_q;
  logic [dmrl_pkg::SpeedW-1:0]  step_size_q;
  logic [dmrl_pkg::PeriodW-1:0] tick_period_q;

  dmrl_pkg::speed_t left_target_q, left_target_d;
  dmrl_pkg::speed_t right_target_q, right_target_d;
  dmrl_pkg::speed_t left_actual_q, left_actual_d;
  dmrl_pkg::speed_t right_actual_q, right_actual_d;
  logic [dmrl_pkg::PeriodW-1:0] wait_count_q, wait_count_d;
  logic done_d;

  logic out_valid_q;
  logic dir_left_q, dir_right_q, ramp_done_q;
  logic [dmrl_pkg::SpeedW-1:0] duty_left_q, duty_right_q;

  logic in_accept;
  logic cfg_write;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q   <= dmrl_pkg::MaxSpeedRst;
      min_speed_q   <= dmrl_pkg::MinSpeedRst;
      step_size_q   <= dmrl_pkg::StepSizeRst;
      tick_period_q <= dmrl_pkg::TickPeriodRst;
    end else if (cfg_write) begin
      unique case (dmrl_pkg::cfg_idx_e'(cfg_index_i))
        dmrl_pkg::CfgMaxSpeed:   max_speed_q   <= cfg_data_i[dmrl_pkg::SpeedW-1:0];
        dmrl_pkg::CfgMinSpeed:   min_speed_q   <= cfg_data_i[dmrl_pkg::SpeedW-1:0];
        dmrl_pkg::CfgStepSize:   step_size_q   <= cfg_data_i[dmrl_pkg::SpeedW-1:0];
        dmrl_pkg::CfgTickPeriod: tick_period_q <= cfg_data_i[dmrl_pkg::PeriodW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    left_target_d  = left_target_q;
    right_target_d = right_target_q;
    left_actual_d  = left_actual_q;
    right_actual_d = right_actual_q;
    wait_count_d   = wait_count_q;
    done_d         = 1'b0;
    if (!kind_i) begin
      left_target_d  = dmrl_pkg::clamp_target(target_left_i, max_speed_q);
      right_target_d = dmrl_pkg::clamp_target(target_right_i, max_speed_q);
    end else if (wait_count_q == '0) begin
      left_actual_d  = dmrl_pkg::ramp(left_actual_q, left_target_q, step_size_q);
      right_actual_d = dmrl_pkg::ramp(right_actual_q, right_target_q, step_size_q);
      wait_count_d   = (tick_period_q == '0) ? '0 : tick_period_q - 1'b1;
      done_d         = 1'b1;
    end else begin
      wait_count_d   = wait_count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_target_q  <= '0;
      right_target_q <= '0;
      left_actual_q  <= '0;
      right_actual_q <= '0;
      wait_count_q   <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (in_accept) begin
        left_target_q  <= left_target_d;
        right_target_q <= right_target_d;
        left_actual_q  <= left_actual_d;
        right_actual_q <= right_actual_d;
        wait_count_q   <= wait_count_d;
        out_valid_q    <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q    <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      dir_left_q   <= left_actual_d[dmrl_pkg::StateW-1];
      dir_right_q  <= right_actual_d[dmrl_pkg::StateW-1];
      duty_left_q  <= dmrl_pkg::drive_mag(left_actual_d, max_speed_q, min_speed_q);
      duty_right_q <= dmrl_pkg::drive_mag(right_actual_d, max_speed_q, min_speed_q);
      ramp_done_q  <= done_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign dir_left_o   = dir_left_q;
  assign duty_left_o  = duty_left_q;
  assign dir_right_o  = dir_right_q;
  assign duty_right_o = duty_right_q;
  assign ramp_done_o  = ramp_done_q;

endmodule

`default_nettype wire

// ===== tb/tb_dual_motor_ramp_limiter_unit.sv =====
// ----------------------------------------------------------------------------
// tb_dual_motor_ramp_limiter_unit: self-checking bench for the ramp limiter
// Drives target and tick items in random bursts against a randomly stalling
// receiver. It reprograms the four limit registers between phases and checks
// every drive result, field by field, against an in-bench predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_dual_motor_ramp_limiter_unit;

  localparam logic        KindTarget = 1'b0;
  localparam logic        KindTick   = 1'b1;
  localparam int unsigned RandPhases = 12;
  localparam int unsigned CycleLimit = 200000;

  typedef logic [dmrl_pkg::SpeedW-1:0]         duty_t;
  typedef logic signed [dmrl_pkg::TargetW-1:0] target_t;
  typedef logic [dmrl_pkg::PeriodW-1:0]        period_t;
  typedef logic [dmrl_pkg::CfgDatW-1:0]        cfg_data_t;

  typedef struct packed {
    logic  dir_l;
    duty_t duty_l;
    logic  dir_r;
    duty_t duty_r;
    logic  done;
  } drive_t;

  typedef enum logic [1:0] {
    StallNone,
    StallLight,
    StallHeavy,
    StallPeriodic
  } stall_mode_e;

  class ramp_drive_predictor;
    duty_t            max_spd;
    duty_t            min_spd;
    duty_t            step;
    period_t          period;
    period_t          wait_cnt;
    dmrl_pkg::speed_t tgt_l;
    dmrl_pkg::speed_t tgt_r;
    dmrl_pkg::speed_t act_l;
    dmrl_pkg::speed_t act_r;
    drive_t           drive_q[$];
    int unsigned      mismatch_cnt;

    function new();
      max_spd      = dmrl_pkg::MaxSpeedRst;
      min_spd      = dmrl_pkg::MinSpeedRst;
      step         = dmrl_pkg::StepSizeRst;
      period       = dmrl_pkg::TickPeriodRst;
      wait_cnt     = '0;
      tgt_l        = '0;
      tgt_r        = '0;
      act_l        = '0;
      act_r        = '0;
      mismatch_cnt = 0;
    endfunction

    function void apply_reg(dmrl_pkg::cfg_idx_e idx, cfg_data_t data);
      case (idx)
        dmrl_pkg::CfgMaxSpeed:   max_spd = data[dmrl_pkg::SpeedW-1:0];
        dmrl_pkg::CfgMinSpeed:   min_spd = data[dmrl_pkg::SpeedW-1:0];
        dmrl_pkg::CfgStepSize:   step    = data[dmrl_pkg::SpeedW-1:0];
        dmrl_pkg::CfgTickPeriod: period  = data[dmrl_pkg::PeriodW-1:0];
        default: ;
      endcase
    endfunction

    function dmrl_pkg::speed_t clamp_to_max(target_t t);
      int v;
      int lim;
      v   = int'(t);
      lim = int'(max_spd);
      if (v > lim) v = lim;
      else if (v < -lim) v = -lim;
      return dmrl_pkg::speed_t'(v);
    endfunction

    function dmrl_pkg::speed_t step_toward(dmrl_pkg::speed_t a, dmrl_pkg::speed_t g);
      int cur;
      int goal;
      cur  = int'(a);
      goal = int'(g);
      if (cur < goal) begin
        cur = cur + int'(step);
        if (cur > goal) cur = goal;
      end else if (cur > goal) begin
        cur = cur - int'(step);
        if (cur < goal) cur = goal;
      end
      return dmrl_pkg::speed_t'(cur);
    endfunction

    function duty_t duty_of(dmrl_pkg::speed_t a);
      int m;
      m = int'(a);
      if (m < 0) m = -m;
      if (m > int'(max_spd)) m = int'(max_spd);
      if (m != 0 && m < int'(min_spd)) m = int'(min_spd);
      return duty_t'(m);
    endfunction

    function void take_item(logic kind, target_t tl, target_t tr);
      drive_t d;
      d.done = 1'b0;
      if (kind == KindTarget) begin
        tgt_l = clamp_to_max(tl);
        tgt_r = clamp_to_max(tr);
      end else if (wait_cnt == '0) begin
        act_l    = step_toward(act_l, tgt_l);
        act_r    = step_toward(act_r, tgt_r);
        wait_cnt = (period == '0) ? '0 : period - 1'b1;
        d.done   = 1'b1;
      end else begin
        wait_cnt = wait_cnt - 1'b1;
      end
      d.dir_l  = (act_l < 0);
      d.duty_l = duty_of(act_l);
      d.dir_r  = (act_r < 0);
      d.duty_r = duty_of(act_r);
      drive_q.push_back(d);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        mismatch_cnt++;
      end
    endfunction

    function void check_drive(drive_t got);
      drive_t want;
      if (drive_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %0b/%0d %0b/%0d done %0b",
                 $time, got.dir_l, got.duty_l, got.dir_r, got.duty_r, got.done);
        mismatch_cnt++;
        return;
      end
      want = drive_q.pop_front();
      compare_field("dir_left", 32'(want.dir_l), 32'(got.dir_l));
      compare_field("duty_left", 32'(want.duty_l), 32'(got.duty_l));
      compare_field("dir_right", 32'(want.dir_r), 32'(got.dir_r));
      compare_field("duty_right", 32'(want.duty_r), 32'(got.duty_r));
      compare_field("ramp_done", 32'(want.done), 32'(got.done));
    endfunction

    function int unsigned pending();
      return drive_q.size();
    endfunction
  endclass

  logic                            clk_i          = 1'b0;
  logic                            rst_ni         = 1'b0;
  logic                            in_valid_i     = 1'b0;
  logic                            kind_i         = 1'b0;
  target_t                         target_left_i  = '0;
  target_t                         target_right_i = '0;
  logic                            out_stall_i    = 1'b0;
  logic                            cfg_valid_i    = 1'b0;
  logic [dmrl_pkg::CfgIdxW-1:0]    cfg_index_i    = '0;
  cfg_data_t                       cfg_data_i     = '0;
  logic                            in_stall_o;
  logic                            out_valid_o;
  logic                            dir_left_o;
  duty_t                           duty_left_o;
  logic                            dir_right_o;
  duty_t                           duty_right_o;
  logic                            ramp_done_o;
  logic                            cfg_ready_o;

  ramp_drive_predictor pred = new();
  drive_t              seen_drive;
  stall_mode_e         stall_mode = StallNone;
  int unsigned         stall_left = 0;
  int unsigned         cycle_cnt  = 0;

  dual_motor_ramp_limiter_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .target_left_i  (target_left_i),
    .target_right_i (target_right_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .dir_left_o     (dir_left_o),
    .duty_left_o    (duty_left_o),
    .dir_right_o    (dir_right_o),
    .duty_right_o   (duty_right_o),
    .ramp_done_o    (ramp_done_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        seen_drive = {dir_left_o, duty_left_o, dir_right_o, duty_right_o, ramp_done_o};
        pred.check_drive(seen_drive);
      end
      if (in_valid_i && !in_stall_o) begin
        pred.take_item(kind_i, target_left_i, target_right_i);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        pred.apply_reg(dmrl_pkg::cfg_idx_e'(cfg_index_i), cfg_data_i);
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      StallNone:  out_stall_i <= 1'b0;
      StallLight: out_stall_i <= ($urandom_range(0, 3) == 0);
      StallHeavy: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:    out_stall_i <= (stall_left[2:0] < 3'd3);
    endcase
  end

  task automatic send_item(logic kind, target_t tl, target_t tr);
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    kind_i         <= kind;
    target_left_i  <= tl;
    target_right_i <= tr;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic idle_cycles(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  task automatic drain_results();
    idle_cycles(1);
    while (pred.pending() != 0) @(negedge clk_i);
  endtask

  task automatic program_reg(dmrl_pkg::cfg_idx_e idx, cfg_data_t data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic program_limits(duty_t mx, duty_t mn, duty_t st, period_t per);
    program_reg(dmrl_pkg::CfgMaxSpeed, cfg_data_t'(mx));
    program_reg(dmrl_pkg::CfgMinSpeed, cfg_data_t'(mn));
    program_reg(dmrl_pkg::CfgStepSize, cfg_data_t'(st));
    program_reg(dmrl_pkg::CfgTickPeriod, cfg_data_t'(per));
  endtask

  function automatic target_t pick_target();
    target_t t;
    case ($urandom_range(0, 9))
      0:       t = target_t'($urandom);
      1:       t = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
      default: t = target_t'(int'($urandom_range(0, 640)) - 320);
    endcase
    return t;
  endfunction

  task automatic run_items(int unsigned count);
    int unsigned remaining;
    int unsigned burst;
    logic        kind;
    remaining = count;
    while (remaining > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > remaining) burst = remaining;
      repeat (burst) begin
        kind = ($urandom_range(0, 99) < 65) ? KindTick : KindTarget;
        send_item(kind, pick_target(), pick_target());
      end
      remaining -= burst;
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
    end
  endtask

  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    duty_t   mx;
    duty_t   mn;
    duty_t   st;
    period_t per;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset limits: first tick ramps by one
    send_item(KindTarget, 16'sd100, -16'sd100);
    send_item(KindTick, '0, '0);
    drain_results();

    // full step, update on every tick
    program_limits(8'd255, 8'd0, 8'd255, 16'd0);
    send_item(KindTarget, 16'sh7fff, 16'sh8000);
    send_item(KindTick, '0, '0);
    send_item(KindTarget, 16'sh8000, 16'sh7fff);
    send_item(KindTick, '0, '0);
    send_item(KindTick, '0, '0);
    send_item(KindTarget, -16'sd1, 16'sd1);
    send_item(KindTarget, 16'sd256, -16'sd256);
    send_item(KindTick, '0, '0);
    send_item(KindTick, '0, '0);
    drain_results();

    // lowered ceiling below floor, zero step
    program_limits(8'd40, 8'd200, 8'd0, 16'd1);
    send_item(KindTick, '0, '0);
    send_item(KindTarget, 16'sd0, 16'sd0);
    send_item(KindTick, '0, '0);
    drain_results();

    program_limits(dmrl_pkg::MaxSpeedRst, dmrl_pkg::MinSpeedRst, dmrl_pkg::StepSizeRst,
                   dmrl_pkg::TickPeriodRst);
    send_item(KindTick, '0, '0);
    send_item(KindTick, '0, '0);
    send_item(KindTarget, -16'sd255, 16'sd255);
    drain_results();

    for (int ph = 0; ph < RandPhases; ph++) begin
      case ($urandom_range(0, 5))
        0:       mx = 8'd0;
        1:       mx = 8'd255;
        default: mx = duty_t'($urandom_range(1, 254));
      endcase
      case ($urandom_range(0, 3))
        0:       mn = 8'd0;
        1:       mn = 8'd255;
        default: mn = duty_t'($urandom_range(0, 80));
      endcase
      case ($urandom_range(0, 5))
        0:       st = 8'd255;
        1:       st = 8'd0;
        default: st = duty_t'($urandom_range(1, 40));
      endcase
      if (ph == RandPhases - 1) begin
        per = 16'hffff;
      end else if ($urandom_range(0, 7) == 0) begin
        per = 16'd0;
      end else begin
        per = period_t'($urandom_range(1, 6));
      end
      program_limits(mx, mn, st, per);
      run_items($urandom_range(90, 120));
      drain_results();
    end

    repeat (4) @(posedge clk_i);
    if (pred.mismatch_cnt == 0 && pred.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/dmrl_pkg.sv
rtl/dual_motor_ramp_limiter_unit.sv
tb/tb_dual_motor_ramp_limiter_unit.sv
